### rtl/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg: shared types and constants of the beacon scheduler
// Profile table, microcode program, register indexes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbts_pkg;

  // Number of SmartBeaconing profiles in the table below
  localparam int ProfileCount = 3;
  localparam int ProfIdxW     = (ProfileCount > 1) ? $clog2(ProfileCount) : 1;

  localparam logic [9:0]  MsPerS    = 10'd1000;
  localparam logic [31:0] WxHoldMs  = 32'd20000;
  localparam logic [15:0] MsPerMin  = 16'd60000;

  // Divider operand widths: fast speed times fast rate, over speed
  localparam int DivW   = 16;
  localparam int DivorW = 8;
  localparam int DivCntW = $clog2(DivW + 1);

  localparam int IntervalW = 18;
  localparam int FixLimW   = 24;  // 255 min in ms
  localparam int StatLimW  = 27;  // 2047 min in ms

  typedef struct packed {
    logic [7:0] slow_rate;   // seconds
    logic [7:0] slow_speed;  // km/h
    logic [7:0] fast_rate;   // seconds
    logic [7:0] fast_speed;  // km/h
  } profile_t;

  localparam profile_t Profiles [ProfileCount] = '{
    '{slow_rate: 8'd120, slow_speed: 8'd3,  fast_rate: 8'd60, fast_speed: 8'd15},
    '{slow_rate: 8'd120, slow_speed: 8'd5,  fast_rate: 8'd60, fast_speed: 8'd40},
    '{slow_rate: 8'd120, slow_speed: 8'd10, fast_rate: 8'd60, fast_speed: 8'd70}
  };

  // Divider request from the sequencer
  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [DivorW-1:0] divisor;
  } div_req_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PROFILE_SELECT    = 3'd0,
    CFG_SMART_ENABLE      = 3'd1,
    CFG_STATIC_ENABLE     = 3'd2,
    CFG_FIXED_RATE_MIN    = 3'd3,
    CFG_STATIC_PERIOD_MIN = 3'd4,
    CFG_TEMP_HIGH_LIMIT   = 3'd5,
    CFG_TEMP_LOW_LIMIT    = 3'd6,
    CFG_LEVEL_LOW_LIMIT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    REASON_NONE   = 3'd0,
    REASON_FIXED  = 3'd1,
    REASON_FIRST  = 3'd2,
    REASON_ALARM  = 3'd3,
    REASON_PERIOD = 3'd4
  } reason_e;

  typedef enum logic [1:0] {
    ALARM_NONE      = 2'd0,
    ALARM_TEMP_HIGH = 2'd1,
    ALARM_TEMP_LOW  = 2'd2,
    ALARM_LEVEL_LOW = 2'd3
  } alarm_e;

  // Microcode: datapath operation of a step
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_WX        = 4'd2,
    OP_SMART     = 4'd3,
    OP_LIMITS    = 4'd4,
    OP_DIV_START = 4'd5,
    OP_INTERVAL  = 4'd6,
    OP_FIXED     = 4'd7,
    OP_STATIC    = 4'd8,
    OP_EMIT      = 4'd9
  } op_e;

  // Microcode: jump condition (taken -> target, else next step)
  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_GOTO      = 3'd1,
    COND_NO_IN     = 3'd2,
    COND_NOT_SMART = 3'd3,
    COND_DIV_BUSY  = 3'd4,
    COND_OUT_FULL  = 3'd5
  } cond_e;

  localparam int StepW = 4;

  localparam logic [StepW-1:0] StepAccept   = 4'd0;
  localparam logic [StepW-1:0] StepWx       = 4'd1;
  localparam logic [StepW-1:0] StepSmart    = 4'd2;
  localparam logic [StepW-1:0] StepLimits   = 4'd3;
  localparam logic [StepW-1:0] StepDivStart = 4'd4;
  localparam logic [StepW-1:0] StepInterval = 4'd5;
  localparam logic [StepW-1:0] StepFixed    = 4'd6;
  localparam logic [StepW-1:0] StepStatic   = 4'd7;
  localparam logic [StepW-1:0] StepEmit     = 4'd8;
  localparam logic [StepW-1:0] StepReturn   = 4'd9;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_GOTO, target: StepAccept};
    unique case (step)
      StepAccept:   w = '{op: OP_ACCEPT,    cond: COND_NO_IN,     target: StepAccept};
      StepWx:       w = '{op: OP_WX,        cond: COND_NEXT,      target: StepAccept};
      StepSmart:    w = '{op: OP_SMART,     cond: COND_NEXT,      target: StepAccept};
      StepLimits:   w = '{op: OP_LIMITS,    cond: COND_NOT_SMART, target: StepFixed};
      StepDivStart: w = '{op: OP_DIV_START, cond: COND_NEXT,      target: StepAccept};
      StepInterval: w = '{op: OP_INTERVAL,  cond: COND_DIV_BUSY,  target: StepInterval};
      StepFixed:    w = '{op: OP_FIXED,     cond: COND_NEXT,      target: StepAccept};
      StepStatic:   w = '{op: OP_STATIC,    cond: COND_NEXT,      target: StepAccept};
      StepEmit:     w = '{op: OP_EMIT,      cond: COND_OUT_FULL,  target: StepEmit};
      StepReturn:   w = '{op: OP_NOP,       cond: COND_GOTO,      target: StepAccept};
      default:      w = '{op: OP_NOP,       cond: COND_GOTO,      target: StepAccept};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/sbts_div.sv
// ----------------------------------------------------------------------------
// sbts_div: serial restoring divider
// One quotient bit per cycle; quotient valid once busy_o falls.
// ----------------------------------------------------------------------------
`default_nettype none

module sbts_div
  import sbts_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire div_req_t        req_i,
  output logic                 busy_o,
  output logic [DivW-1:0]      quotient_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q, quo_d;     // dividend shifts out, quotient shifts in
  logic [DivorW-1:0]  rem_q, rem_d;
  logic [DivorW-1:0]  divisor_q, divisor_d;
  logic [DivorW:0]    trial;
  logic               fits;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DivW-2:0], fits};
      rem_d = fits ? DivorW'(trial - {1'b0, divisor_q}) : DivorW'(trial);
    end else if (req_i.start) begin
      cnt_d     = DivCntW'(DivW);
      quo_d     = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && divisor_q != '0) |-> (rem_q < divisor_q))
    else $error("sbts_div: remainder out of range");

  // A start on an idle divider begins a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && req_i.start) |=> (cnt_q == DivCntW'(DivW)))
    else $error("sbts_div: start not taken");

  // A run counts down one step per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("sbts_div: iteration count skipped");

endmodule

`default_nettype wire

### rtl/smart_beacon_tx_scheduler_top.sv
// ----------------------------------------------------------------------------
// smart_beacon_tx_scheduler_top: beacon transmit scheduler
// Microcoded pass over one scheduling transaction per input item.
// ----------------------------------------------------------------------------
// Each input transaction is one scheduling pass and yields exactly one result
// transaction. A short microprogram walks the pass: weather-hold update,
// smart-mode decision, SmartBeaconing interval (using a serial divider for
// fast_speed*fast_rate/speed), fixed-rate check, then static-mode alarm and
// period logic. With smart mode on, the pass waits on the 16-bit serial
// divider; without smart mode it skips the divider steps. The result sits in
// an output register, so the next input is taken while the previous result
// still waits on the master side. Configuration writes are registered and
// must happen only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module smart_beacon_tx_scheduler_top
  import sbts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] now_ms, [39:32] speed_kmh, [51:40] temperature_dt,
  // [61:52] water_level_dp, [93:62] last_tx_ms, [94] weather_request
  input  wire logic [95:0] s_axis_tdata_i,
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] send_update, [3:1] send_reason, [21:4] tx_interval_ms,
  // [22] smart_active, [23] weather_pending, [25:24] alarm_code
  output logic [31:0]      m_axis_tdata_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]         profile_select_q;
  logic               smart_enable_q;
  logic               static_enable_q;
  logic [7:0]         fixed_rate_min_q;
  logic [10:0]        static_period_min_q;
  logic signed [11:0] temp_high_limit_q;
  logic signed [11:0] temp_low_limit_q;
  logic [9:0]         level_low_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_select_q    <= 2'd0;
      smart_enable_q      <= 1'b0;
      static_enable_q     <= 1'b0;
      fixed_rate_min_q    <= 8'd15;
      static_period_min_q <= 11'd10;
      temp_high_limit_q   <= 12'sd500;
      temp_low_limit_q    <= 12'sd0;
      level_low_limit_q   <= 10'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PROFILE_SELECT:    profile_select_q    <= cfg_wdata_i[1:0];
        CFG_SMART_ENABLE:      smart_enable_q      <= cfg_wdata_i[0];
        CFG_STATIC_ENABLE:     static_enable_q     <= cfg_wdata_i[0];
        CFG_FIXED_RATE_MIN:    fixed_rate_min_q    <= cfg_wdata_i[7:0];
        CFG_STATIC_PERIOD_MIN: static_period_min_q <= cfg_wdata_i[10:0];
        CFG_TEMP_HIGH_LIMIT:   temp_high_limit_q   <= $signed(cfg_wdata_i);
        CFG_TEMP_LOW_LIMIT:    temp_low_limit_q    <= $signed(cfg_wdata_i);
        CFG_LEVEL_LOW_LIMIT:   level_low_limit_q   <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [StepW-1:0] pc_q, pc_d;
  ucode_t           uc;
  logic             in_fire;
  logic             out_full;
  logic             div_busy;
  logic [DivW-1:0]  div_quo;
  div_req_t         div_req;
  logic             smart_q;
  logic             take;

  assign uc              = ucode_rom(pc_q);
  assign s_axis_tready_o = (uc.op == OP_ACCEPT);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    unique case (uc.cond)
      COND_NEXT:      take = 1'b0;
      COND_GOTO:      take = 1'b1;
      COND_NO_IN:     take = !in_fire;
      COND_NOT_SMART: take = !smart_q;
      COND_DIV_BUSY:  take = div_busy;
      COND_OUT_FULL:  take = out_full;
      default:        take = 1'b1;
    endcase
    pc_d = take ? uc.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepAccept;
    end else begin
      pc_q <= pc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input latch
  // --------------------------------------------------------------------------
  logic [31:0]        now_q;
  logic [7:0]         speed_q;
  logic signed [11:0] temp_q;
  logic [9:0]         level_q;
  logic [31:0]        last_tx_q;
  logic               wx_req_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q     <= s_axis_tdata_i[31:0];
      speed_q   <= s_axis_tdata_i[39:32];
      temp_q    <= $signed(s_axis_tdata_i[51:40]);
      level_q   <= s_axis_tdata_i[61:52];
      last_tx_q <= s_axis_tdata_i[93:62];
      wx_req_q  <= s_axis_tdata_i[94];
    end
  end

  // --------------------------------------------------------------------------
  // Weather hold
  // --------------------------------------------------------------------------
  logic        wx_hold_q, wx_hold_d;
  logic [31:0] wx_start_q, wx_start_d;
  logic [31:0] wx_age;

  always_comb begin
    wx_hold_d  = wx_req_q | wx_hold_q;
    wx_start_d = wx_req_q ? now_q : wx_start_q;
    wx_age     = now_q - wx_start_d;
    if (wx_age > WxHoldMs) begin
      wx_hold_d = 1'b0;   // hold expired (wrapping age)
    end
  end

  // --------------------------------------------------------------------------
  // Period limits in ms, computed once per pass
  // --------------------------------------------------------------------------
  logic [FixLimW-1:0]  fixed_lim_q;
  logic [StatLimW-1:0] static_lim_q;

  // --------------------------------------------------------------------------
  // Smart interval
  // --------------------------------------------------------------------------
  logic [ProfIdxW-1:0]  prof_idx;
  profile_t             prof;
  logic [7:0]           rate_s;
  logic [IntervalW-1:0] interval_new;
  logic [IntervalW-1:0] interval_hold_q;

  // out-of-range selects saturate to the last profile
  assign prof_idx = (int'(profile_select_q) >= ProfileCount) ?
                    ProfIdxW'(ProfileCount - 1) : ProfIdxW'(profile_select_q);
  assign prof     = Profiles[prof_idx];

  assign div_req.start    = (uc.op == OP_DIV_START);
  assign div_req.dividend = DivW'(prof.fast_speed) * DivW'(prof.fast_rate);
  assign div_req.divisor  = speed_q;

  sbts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_comb begin
    priority if (speed_q < prof.slow_speed) begin
      rate_s = prof.slow_rate;
    end else if (speed_q > prof.fast_speed) begin
      rate_s = prof.fast_rate;
    end else if (speed_q == '0) begin
      rate_s = prof.slow_rate;      // guarded zero divisor
    end else if (div_quo > DivW'(prof.slow_rate)) begin
      rate_s = prof.slow_rate;
    end else begin
      rate_s = div_quo[7:0];
    end
    interval_new = IntervalW'(rate_s) * IntervalW'(MsPerS);
  end

  // --------------------------------------------------------------------------
  // Alarm
  // --------------------------------------------------------------------------
  alarm_e alarm;

  always_comb begin
    priority if (temp_q > temp_high_limit_q) begin
      alarm = ALARM_TEMP_HIGH;
    end else if (temp_q < temp_low_limit_q) begin
      alarm = ALARM_TEMP_LOW;
    end else if (level_q < level_low_limit_q) begin
      alarm = ALARM_LEVEL_LOW;
    end else begin
      alarm = ALARM_NONE;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers, written by the step's operation
  // --------------------------------------------------------------------------
  logic        send_q;
  reason_e     reason_q;
  alarm_e      alarm_q;
  logic        static_started_q;
  logic [31:0] static_last_q;
  logic [31:0] fixed_age;
  logic [31:0] static_age;

  assign fixed_age  = now_q - last_tx_q;
  assign static_age = now_q - static_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_hold_q        <= 1'b0;
      wx_start_q       <= '0;
      smart_q          <= 1'b0;
      interval_hold_q  <= '0;
      static_started_q <= 1'b0;
      static_last_q    <= '0;
      send_q           <= 1'b0;
      reason_q         <= REASON_NONE;
      alarm_q          <= ALARM_NONE;
      fixed_lim_q      <= '0;
      static_lim_q     <= '0;
    end else begin
      unique case (uc.op)
        OP_WX: begin
          wx_hold_q  <= wx_hold_d;
          wx_start_q <= wx_start_d;
        end
        OP_SMART: begin
          smart_q <= !wx_hold_q && smart_enable_q;
        end
        OP_LIMITS: begin
          fixed_lim_q  <= FixLimW'(fixed_rate_min_q) * FixLimW'(MsPerMin);
          static_lim_q <= StatLimW'(static_period_min_q) * StatLimW'(MsPerMin);
        end
        OP_INTERVAL: begin
          if (!div_busy) begin
            interval_hold_q <= interval_new;
          end
        end
        OP_FIXED: begin
          if (!smart_q && fixed_age >= 32'(fixed_lim_q)) begin
            send_q   <= 1'b1;
            reason_q <= REASON_FIXED;
          end else begin
            send_q   <= 1'b0;
            reason_q <= REASON_NONE;
          end
        end
        OP_STATIC: begin
          alarm_q <= static_enable_q ? alarm : ALARM_NONE;
          if (static_enable_q) begin
            priority if (!static_started_q) begin
              send_q           <= 1'b1;
              reason_q         <= REASON_FIRST;
              static_started_q <= 1'b1;
              static_last_q    <= now_q;
            end else if (alarm != ALARM_NONE) begin
              send_q        <= 1'b1;
              reason_q      <= REASON_ALARM;
              static_last_q <= now_q;
            end else if (static_age >= 32'(static_lim_q)) begin
              send_q        <= 1'b1;
              reason_q      <= REASON_PERIOD;
              static_last_q <= now_q;
            end else begin
              // fixed-rate outcome stands
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  typedef struct packed {
    alarm_e               alarm_code;
    logic                 weather_pending;
    logic                 smart_active;
    logic [IntervalW-1:0] tx_interval_ms;
    reason_e              send_reason;
    logic                 send_update;
  } result_t;

  logic    out_valid_q;
  logic    out_load;
  result_t out_q;

  assign out_full = out_valid_q && !m_axis_tready_i;
  assign out_load = (uc.op == OP_EMIT) && !out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{alarm_code:      alarm_q,
                 weather_pending: wx_hold_q,
                 smart_active:    smart_q,
                 tx_interval_ms:  interval_hold_q,
                 send_reason:     reason_q,
                 send_update:     send_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // once decided, smart mode never coexists with a weather hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q > StepSmart && smart_q) |-> !wx_hold_q)
    else $error("smart mode active during weather hold");

  // interval only moves in the interval step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q != StepInterval) |=> $stable(interval_hold_q))
    else $error("interval changed outside its step");

  // divider is idle whenever a new transaction can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("divider busy at input");

  // a pending result reports a reason exactly when a beacon is due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.send_update == (out_q.send_reason != REASON_NONE)))
    else $error("send flag and reason disagree");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for smart_beacon_tx_scheduler_top
// Drives scheduling passes through the input stream, predicts each verdict
// with a behavioral scheduler model and checks every result transaction.
// ----------------------------------------------------------------------------
// A short directed part runs first: reset-default registers, the time wrap,
// the weather hold boundary, every SmartBeaconing band, each alarm and each
// send reason, and a profile number past the end of the table. Random phases
// follow, one register setting each, with mostly advancing time so that
// weather holds, alarms and both beacon periods come and go. The sender
// works in bursts; the receiver stalls on its own pattern and twice holds
// off for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import sbts_pkg::*;
();

  localparam logic [31:0] HoldWindowMs = 32'd20000;
  localparam int unsigned MinuteMs     = 60000;
  localparam int          SettleCycles = 40;

  // One scheduling pass, packed as on s_axis_tdata (last field lowest)
  typedef struct packed {
    logic        wx_req;
    logic [31:0] last_tx_ms;
    logic [9:0]  level;
    logic [11:0] temp;
    logic [7:0]  speed;
    logic [31:0] now_ms;
  } pass_t;

  // One verdict, packed as on m_axis_tdata
  typedef struct packed {
    alarm_e      alarm;
    logic        wx_pending;
    logic        smart;
    logic [17:0] interval;
    reason_e     reason;
    logic        send;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  profile;
    logic        smart_en;
    logic        static_en;
    logic [7:0]  fixed_min;
    logic [10:0] static_min;
    logic [11:0] temp_high;
    logic [11:0] temp_low;
    logic [9:0]  level_low;
  } beacon_cfg_t;

  // DUT connections; the driven inputs are known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = '0;
  logic [11:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  // Register copy and scheduler state of the model (reset values)
  beacon_cfg_t cfg = '{profile: 2'd0, smart_en: 1'b0, static_en: 1'b0,
                       fixed_min: 8'd15, static_min: 11'd10, temp_high: 12'd500,
                       temp_low: 12'd0, level_low: 10'd200};
  logic        smart_now         = 1'b0;
  logic [17:0] interval_ms       = '0;
  logic        wx_hold           = 1'b0;
  logic [31:0] wx_start_ms       = '0;
  logic [31:0] static_last_ms    = '0;
  logic        static_sent_first = 1'b0;

  pass_t    pass_q[$];     // passes waiting to go out
  verdict_t verdict_q[$];  // predicted verdicts of accepted passes

  logic [31:0] stim_now = '0;  // time base of the random passes
  int mismatches    = 0;
  int passes_sent   = 0;
  int results_seen  = 0;
  int settings_used = 1;  // reset defaults count as one
  int smart_passes  = 0;
  int held_passes   = 0;
  int reason_count[8];

  smart_beacon_tx_scheduler_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scheduler model
  // --------------------------------------------------------------------------

  // SmartBeaconing interval in ms; selections past the table use the last one
  function automatic int unsigned beacon_interval_ms(input logic [1:0] sel,
                                                     input logic [7:0] spd);
    int unsigned slow_spd, fast_spd, q;
    case (sel)
      2'd0:    begin slow_spd = 3;  fast_spd = 15; end
      2'd1:    begin slow_spd = 5;  fast_spd = 40; end
      default: begin slow_spd = 10; fast_spd = 70; end
    endcase
    if (spd < slow_spd) return 120 * 1000;
    if (spd > fast_spd) return 60 * 1000;
    if (spd == 0) return 120 * 1000;
    q = (fast_spd * 60) / spd;
    if (q > 120) q = 120;
    return q * 1000;
  endfunction

  // One pass: updates the model state and returns the verdict
  function automatic verdict_t schedule_pass(input pass_t p);
    verdict_t    r;
    logic [31:0] elapsed;
    logic [31:0] limit;
    int          t, hi, lo;
    r = '0;
    if (p.wx_req) begin
      wx_hold     = 1'b1;
      wx_start_ms = p.now_ms;
    end
    elapsed = p.now_ms - wx_start_ms;
    if (wx_hold && elapsed > HoldWindowMs) wx_hold = 1'b0;
    smart_now = !wx_hold && cfg.smart_en;
    if (smart_now) interval_ms = 18'(beacon_interval_ms(cfg.profile, p.speed));

    elapsed = p.now_ms - p.last_tx_ms;
    limit   = cfg.fixed_min * MinuteMs;
    if (!smart_now && elapsed >= limit) begin
      r.send   = 1'b1;
      r.reason = REASON_FIXED;
    end

    if (cfg.static_en) begin
      t  = $signed(p.temp);
      hi = $signed(cfg.temp_high);
      lo = $signed(cfg.temp_low);
      if (t > hi)                      r.alarm = ALARM_TEMP_HIGH;
      else if (t < lo)                 r.alarm = ALARM_TEMP_LOW;
      else if (p.level < cfg.level_low) r.alarm = ALARM_LEVEL_LOW;

      elapsed = p.now_ms - static_last_ms;
      limit   = cfg.static_min * MinuteMs;
      // static reasons override a fixed-rate beacon due in the same pass
      if (!static_sent_first) begin
        r.send            = 1'b1;
        r.reason          = REASON_FIRST;
        static_sent_first = 1'b1;
        static_last_ms    = p.now_ms;
      end else if (r.alarm != ALARM_NONE) begin
        r.send         = 1'b1;
        r.reason       = REASON_ALARM;
        static_last_ms = p.now_ms;
      end else if (elapsed >= limit) begin
        r.send         = 1'b1;
        r.reason       = REASON_PERIOD;
        static_last_ms = p.now_ms;
      end
    end

    r.interval   = interval_ms;
    r.smart      = smart_now;
    r.wx_pending = wx_hold;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of passes with random gaps
  // --------------------------------------------------------------------------
  pass_t offered;
  int    burst_left = 0;
  int    gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        verdict_q.push_back(schedule_pass(offered));
        passes_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pass_q.size() > 0) begin
          offered = pass_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {1'b0, offered};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: receiver stalls and verdict check
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  verdict_t want_v, got_v;
  int run_left     = 0;
  int stall_left   = 0;
  int hold_off     = 0;
  int next_hold_at = 100;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_v = verdict_t'(m_axis_tdata_o[25:0]);
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result transaction with no pass outstanding: %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want_v = verdict_q.pop_front();
          check_field("send_update", want_v.send, got_v.send);
          check_field("send_reason", want_v.reason, got_v.reason);
          check_field("tx_interval_ms", want_v.interval, got_v.interval);
          check_field("smart_active", want_v.smart, got_v.smart);
          check_field("weather_pending", want_v.wx_pending, got_v.wx_pending);
          check_field("alarm_code", want_v.alarm, got_v.alarm);
          reason_count[want_v.reason]++;
          if (want_v.smart) smart_passes++;
          if (want_v.wx_pending) held_passes++;
        end
      end
      // long hold-offs mid-phase back the block up into its input
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready_i <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
        hold_off     = 300;
        next_hold_at = next_hold_at + 250;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(1, 40);
          stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_pass(input logic [31:0] now, input logic [7:0] spd,
                          input logic [11:0] temp, input logic [9:0] lvl,
                          input logic [31:0] last, input logic wx);
    pass_t p;
    p = '{wx_req: wx, last_tx_ms: last, level: lvl, temp: temp, speed: spd,
          now_ms: now};
    pass_q.push_back(p);
  endtask

  function automatic beacon_cfg_t make_cfg(input logic [1:0] prof, input logic smart,
                                           input logic stat, input logic [7:0] fix,
                                           input logic [10:0] per,
                                           input logic [11:0] hi,
                                           input logic [11:0] lo,
                                           input logic [9:0] lvl);
    beacon_cfg_t c;
    c = '{profile: prof, smart_en: smart, static_en: stat, fixed_min: fix,
          static_min: per, temp_high: hi, temp_low: lo, level_low: lvl};
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  // Only called with nothing in flight
  task automatic load_settings(input beacon_cfg_t c);
    cfg = c;
    settings_used++;
    write_reg(CFG_PROFILE_SELECT, 12'(c.profile));
    write_reg(CFG_SMART_ENABLE, 12'(c.smart_en));
    write_reg(CFG_STATIC_ENABLE, 12'(c.static_en));
    write_reg(CFG_FIXED_RATE_MIN, 12'(c.fixed_min));
    write_reg(CFG_STATIC_PERIOD_MIN, 12'(c.static_min));
    write_reg(CFG_TEMP_HIGH_LIMIT, c.temp_high);
    write_reg(CFG_TEMP_LOW_LIMIT, c.temp_low);
    write_reg(CFG_LEVEL_LOW_LIMIT, 12'(c.level_low));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender pause: nothing queued, offered or outstanding
  task automatic wait_for_drain();
    while (pass_q.size() > 0 || s_axis_tvalid_i || verdict_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly advancing time with sensor readings inside the limits, plus noise
  task automatic queue_random_passes(input int count);
    pass_t       p;
    int unsigned scale, fixed_ms, pick;
    int          lo, hi;
    scale = MinuteMs * (cfg.static_en ? cfg.static_min : 11'(cfg.fixed_min));
    if (scale == 0) scale = MinuteMs;
    fixed_ms = cfg.fixed_min * MinuteMs;
    lo = $signed(cfg.temp_low);
    hi = $signed(cfg.temp_high);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      stim_now = stim_now + $urandom_range(0, 3000);
      else if (pick < 60) stim_now = stim_now + $urandom_range(19990, 20010);
      else if (pick < 90) stim_now = stim_now + $urandom_range(0, scale / 2);
      else if (pick < 95) stim_now = stim_now;
      else                stim_now = $urandom;
      p.now_ms = stim_now;

      pick = $urandom_range(0, 99);
      if (pick < 30)      p.last_tx_ms = stim_now - fixed_ms + $urandom_range(0, 2) - 1;
      else if (pick < 85) p.last_tx_ms = stim_now - $urandom_range(0, 2 * fixed_ms + 1000);
      else                p.last_tx_ms = $urandom;

      p.speed  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80)
                                             : $urandom_range(0, 255);
      p.wx_req = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 6 && lo <= hi) begin
        p.temp  = 12'(lo + int'($urandom_range(0, hi - lo)));
        p.level = 10'(cfg.level_low + $urandom_range(0, 1023 - cfg.level_low));
      end else begin
        p.temp  = 12'($urandom_range(0, 4095));
        p.level = 10'($urandom_range(0, 1023));
      end
      pass_q.push_back(p);
    end
  endtask

  initial begin
    logic [31:0] base;
    beacon_cfg_t next_cfg;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: fixed 15 min beacon, boundary, time wrap, field extremes,
    // weather hold held at exactly 20 s and cleared one ms later
    add_pass(32'd0, 8'd0, 12'd0, 10'd0, 32'd0, 1'b0);
    add_pass(32'd900000, 8'd255, 12'h7FF, 10'd1023, 32'd0, 1'b0);
    add_pass(32'd899999, 8'd0, 12'h800, 10'd0, 32'd0, 1'b0);
    add_pass(32'd10, 8'd1, 12'd100, 10'd500, 32'd10 - 32'd900000, 1'b0);
    add_pass(32'hFFFF_FFFF, 8'd255, 12'h7FF, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    add_pass(32'd19999, 8'd20, 12'd250, 10'd500, 32'd19999, 1'b0);
    add_pass(32'd20000, 8'd20, 12'd250, 10'd500, 32'd20000, 1'b0);
    wait_for_drain();

    // Profile 0 bands, first beacon with alarm, each alarm, limit boundaries,
    // period expiry, fixed and static beacons due together
    load_settings(make_cfg(2'd0, 1'b1, 1'b1, 8'd1, 11'd1, 12'd500, 12'd0, 10'd200));
    base = 32'd1000000;
    add_pass(base,          8'd0,   12'd600,  10'd500, base, 1'b0);
    add_pass(base + 1000,   8'd2,   12'd250,  10'd500, base, 1'b0);
    add_pass(base + 2000,   8'd3,   -12'sd5,  10'd500, base, 1'b0);
    add_pass(base + 3000,   8'd8,   12'd250,  10'd100, base, 1'b0);
    add_pass(base + 4000,   8'd15,  12'd500,  10'd200, base - 1000000, 1'b0);
    add_pass(base + 5000,   8'd16,  12'd0,    10'd200, base, 1'b0);
    add_pass(base + 64000,  8'd255, 12'd250,  10'd500, base + 64000, 1'b0);
    add_pass(base + 65000,  8'd5,   12'd1251, 10'd500, base, 1'b1);
    add_pass(base + 85000,  8'd5,   12'd250,  10'd500, base + 85000, 1'b0);
    add_pass(base + 85001,  8'd5,   12'd250,  10'd500, base + 85001, 1'b0);
    wait_for_drain();

    // Profile number past the table, zero periods, static mode off
    load_settings(make_cfg(2'd3, 1'b1, 1'b0, 8'd0, 11'd0, 12'h7FF, 12'h800, 10'd1023));
    base = 32'h8000_0000;
    add_pass(base,       8'd9,  12'h7FF, 10'd0, base, 1'b0);
    add_pass(base + 10,  8'd10, 12'h800, 10'd0, base, 1'b0);
    add_pass(base + 20,  8'd11, 12'd0,   10'd0, base, 1'b0);
    add_pass(base + 30,  8'd40, 12'd0,   10'd0, base, 1'b0);
    add_pass(base + 40,  8'd70, 12'd0,   10'd0, base, 1'b0);
    add_pass(base + 50,  8'd71, 12'd0,   10'd0, base, 1'b0);
    add_pass(base + 60,  8'd40, 12'd0,   10'd0, base + 60, 1'b1);
    add_pass(base + 70,  8'd40, 12'd0,   10'd0, base + 70, 1'b0);
    wait_for_drain();

    // Random phases, one register setting each
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: next_cfg = make_cfg(2'd0, 1'b1, 1'b1, 8'd1, 11'd1, 12'd500, 12'd0, 10'd200);
        1: next_cfg = make_cfg(2'd1, 1'b1, 1'b0, 8'd255, 11'd1440, 12'd500, 12'd0,
                               10'd200);
        2: next_cfg = make_cfg(2'd2, 1'b0, 1'b1, 8'd15, 11'd0, 12'd1250, -12'sd400,
                               10'd1000);
        3: next_cfg = make_cfg(2'd3, 1'b1, 1'b1, 8'd0, 11'd2047, 12'h7FF, 12'h800,
                               10'd0);
        4: next_cfg = make_cfg(2'd1, 1'b0, 1'b1, 8'd2, 11'd1, -12'sd400, 12'd1250,
                               10'd1023);
        default: next_cfg = make_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     11'($urandom_range(0, 30)),
                                     12'(-400 + $urandom_range(0, 1650)),
                                     12'(-400 + $urandom_range(0, 1650)),
                                     10'($urandom_range(0, 1023)));
      endcase
      load_settings(next_cfg);
      if (ph == 3) stim_now = 32'hFFFF_0000;  // walk across the wrap
      queue_random_passes(70);
      wait_for_drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d predicted results never arrived", verdict_q.size());
      mismatches++;
    end

    $display("Ran %0d scheduling passes over %0d register settings; %0d in smart mode,",
             passes_sent, settings_used, smart_passes);
    $display("%0d under weather hold; beacons due: fixed %0d, first %0d, alarm %0d, period %0d",
             held_passes, reason_count[REASON_FIXED], reason_count[REASON_FIRST],
             reason_count[REASON_ALARM], reason_count[REASON_PERIOD]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("timeout with %0d passes queued and %0d results outstanding",
             pass_q.size(), verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
